/* rtl/circular_byte_buffer_with_bookmark_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the circular byte buffer
// Immediate-consequence and next-cycle property checks, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_BYTE_BUFFER_WITH_BOOKMARK_MACROS_SVH
`define CIRCULAR_BYTE_BUFFER_WITH_BOOKMARK_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent
`define CBB_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbb: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define CBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbb: next-cycle check failed");
`else
`define CBB_ASSERT(label, clk, rst, ante, cons)
`define CBB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/cbb_pkg.sv */
// ----------------------------------------------------------------------------
// cbb_pkg
// Types, codes and constants shared by the circular byte buffer modules.
// ----------------------------------------------------------------------------
package cbb_pkg;

  localparam int DEPTH_DEFAULT = 64;
  // Width for ring index arithmetic: holds the sum of two values below DEPTH
  localparam int ARITH_W = 8;
  localparam int LEN_W = 7;
  localparam int CAP_W = 7;

  typedef enum logic [1:0] {
    OP_STORE       = 2'd0,
    OP_MARK        = 2'd1,
    OP_READ_RECENT = 2'd2,
    OP_READ_MARK   = 2'd3
  } cbb_op_t;

  typedef enum logic [1:0] {
    ORG_MARK    = 2'd0,
    ORG_NEWEST  = 2'd1,
    ORG_OLDEST  = 2'd2,
    ORG_UNKNOWN = 2'd3
  } cbb_origin_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ARG  = 2'd1,
    ST_SIZE = 2'd2,
    ST_MARK = 2'd3
  } cbb_status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_DECIDE = 2'd1,
    S_SEND   = 2'd2
  } cbb_state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic [1:0] mark_origin;
    logic [5:0] distance;
    logic [6:0] length;
  } cbb_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       has_data;
    logic [1:0] status;
    logic       last;
  } cbb_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic single;
    logic fetch;
    logic first;
  } cbb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic read_go;
    logic out_last;
  } cbb_stat_t;

endpackage

/* rtl/cbb_ctrl.sv */
// ----------------------------------------------------------------------------
// cbb_ctrl
// Sequencer: takes one transaction, decides it, then streams its results.
// ----------------------------------------------------------------------------
module cbb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cbb_pkg::cbb_stat_t stat,
  output cbb_pkg::cbb_cmd_t  cmd
);

  cbb_pkg::cbb_state_t state;
  cbb_pkg::cbb_state_t state_next;

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cbb_pkg::S_IDLE: begin
        if (in_valid) state_next = cbb_pkg::S_DECIDE;
      end
      cbb_pkg::S_DECIDE: begin
        state_next = cbb_pkg::S_SEND;
      end
      cbb_pkg::S_SEND: begin
        if (out_ready && stat.out_last) state_next = cbb_pkg::S_IDLE;
      end
      default: begin
        state_next = cbb_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd         = '0;
    case (state)
      cbb_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      cbb_pkg::S_DECIDE: begin
        cmd.single = !stat.read_go;
        cmd.fetch  = stat.read_go;
        cmd.first  = stat.read_go;
      end
      cbb_pkg::S_SEND: begin
        out_valid = 1'b1;
        // Fetch the next byte on the edge that takes the current one
        cmd.fetch = out_ready && !stat.out_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* rtl/cbb_dpath.sv */
// ----------------------------------------------------------------------------
// cbb_dpath
// Ring memory, positions, bookmark, decision logic and result register.
// ----------------------------------------------------------------------------
`include "circular_byte_buffer_with_bookmark_macros.svh"

module cbb_dpath #(
  parameter int DEPTH = cbb_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cbb_pkg::CAP_W-1:0]   cfg_wdata,
  input  cbb_pkg::cbb_in_t            in_data,
  input  cbb_pkg::cbb_cmd_t           cmd,
  output cbb_pkg::cbb_stat_t          stat,
  output cbb_pkg::cbb_out_t           out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = cbb_pkg::ARITH_W;
  localparam int LW = cbb_pkg::LEN_W;

  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                            input logic [AW-1:0] m);
    logic [AW-1:0] s;
    s = a + b;
    if (s >= m) s = s - m;
    return s;
  endfunction

  function automatic logic [AW-1:0] mod_sub(input logic [AW-1:0] a, input logic [AW-1:0] b,
                                            input logic [AW-1:0] m);
    logic [AW-1:0] s;
    if (a >= b) s = a - b;
    else s = a + m - b;
    return s;
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [CW-1:0] cap;
  logic [PW-1:0] wp;
  logic [CW-1:0] fill;
  logic [PW-1:0] mp;
  logic          mv;
  cbb_pkg::cbb_in_t item;
  logic [PW-1:0] idx;
  logic [LW-1:0] cnt;
  logic [7:0]    rd_byte;
  logic          has;
  logic [1:0]    status;
  logic          last;

  logic [AW-1:0] cap_e, wp_e, mp_e, fill_e, dist_e, len_e;
  logic [AW-1:0] span, mark_new, wp_adv, start_e, next_e;
  logic [1:0]    mark_status, single_status;
  logic          store_hit, read_go;
  logic [PW-1:0] addr;
  logic [LW-1:0] cnt_next;
  logic          fetch_last;
  logic [CW-1:0] cap_w;

  assign cap_e  = AW'(cap);
  assign wp_e   = AW'(wp);
  assign mp_e   = AW'(mp);
  assign fill_e = AW'(fill);
  assign dist_e = AW'(item.distance);
  assign len_e  = AW'(item.length);

  assign store_hit = mv && (wp == mp);
  assign wp_adv    = mod_add(wp_e, AW'(1), cap_e);

  // Decide the bookmark placement
  always_comb begin
    span        = mod_sub(wp_e, mp_e, cap_e);
    if (span == '0) span = cap_e;
    mark_new    = mp_e;
    mark_status = cbb_pkg::ST_OK;
    case (item.mark_origin)
      cbb_pkg::ORG_MARK: begin
        if (!mv) mark_status = cbb_pkg::ST_MARK;
        else if (dist_e >= span) mark_status = cbb_pkg::ST_SIZE;
        else mark_new = mod_add(mp_e, dist_e, cap_e);
      end
      cbb_pkg::ORG_NEWEST: begin
        if (dist_e >= fill_e) mark_status = cbb_pkg::ST_SIZE;
        else mark_new = mod_sub(mod_sub(wp_e, dist_e, cap_e), AW'(1), cap_e);
      end
      cbb_pkg::ORG_OLDEST: begin
        if (dist_e >= fill_e) mark_status = cbb_pkg::ST_SIZE;
        else mark_new = mod_add(mod_sub(wp_e, fill_e, cap_e), dist_e, cap_e);
      end
      default: begin
        mark_status = cbb_pkg::ST_ARG;
      end
    endcase
  end

  // Decide the single-result answer or a read stream
  always_comb begin
    single_status = cbb_pkg::ST_OK;
    read_go       = 1'b0;
    start_e       = mp_e;
    case (item.operation)
      cbb_pkg::OP_STORE: begin
        if (store_hit) single_status = cbb_pkg::ST_MARK;
      end
      cbb_pkg::OP_MARK: begin
        single_status = mark_status;
      end
      cbb_pkg::OP_READ_RECENT: begin
        start_e = mod_sub(wp_e, len_e, cap_e);
        if (item.length == '0) single_status = cbb_pkg::ST_ARG;
        else if (len_e > fill_e) single_status = cbb_pkg::ST_SIZE;
        else read_go = 1'b1;
      end
      default: begin
        if (item.length == '0) single_status = cbb_pkg::ST_ARG;
        else if (!mv) single_status = cbb_pkg::ST_MARK;
        else read_go = 1'b1;
      end
    endcase
  end

  // Stream address, count and end of stream
  assign addr       = cmd.first ? start_e[PW-1:0] : idx;
  assign next_e     = mod_add(AW'(addr), AW'(1), cap_e);
  assign cnt_next   = (cmd.first ? LW'(0) : cnt) + LW'(1);
  assign fetch_last = (cnt_next == item.length) ||
                      ((item.operation == cbb_pkg::OP_READ_MARK) && (next_e[PW-1:0] == wp));

  // Clamp the written capacity to 1..DEPTH
  always_comb begin
    if (cfg_wdata == '0) cap_w = CW'(1);
    else if (cfg_wdata > cbb_pkg::CAP_W'(DEPTH)) cap_w = CW'(DEPTH);
    else cap_w = cfg_wdata[CW-1:0];
  end

  // Update positions, fill count and bookmark
  always_ff @(posedge clk) begin
    if (rst) begin
      cap  <= CW'(DEPTH);
      wp   <= '0;
      fill <= '0;
      mp   <= '0;
      mv   <= 1'b0;
    end else if (cfg_we) begin
      cap  <= cap_w;
      wp   <= '0;
      fill <= '0;
      mp   <= '0;
      mv   <= 1'b0;
    end else if (cmd.single) begin
      if (item.operation == cbb_pkg::OP_STORE) begin
        wp <= wp_adv[PW-1:0];
        if (fill < cap) fill <= fill + CW'(1);
        if (store_hit) mv <= 1'b0;
      end else if (item.operation == cbb_pkg::OP_MARK) begin
        if (mark_status == cbb_pkg::ST_OK) begin
          mp <= mark_new[PW-1:0];
          mv <= 1'b1;
        end
      end
    end
  end

  // Capture the transaction, advance the stream
  always_ff @(posedge clk) begin
    if (cmd.capture) item <= in_data;
    if (cmd.fetch) begin
      idx <= next_e[PW-1:0];
      cnt <= cnt_next;
    end
  end

  // Ring memory with registered read into the result register
  always_ff @(posedge clk) begin
    if (cmd.single && (item.operation == cbb_pkg::OP_STORE)) mem[wp] <= item.data_byte;
    if (cmd.fetch) begin
      rd_byte <= mem[addr];
      has     <= 1'b1;
      status  <= cbb_pkg::ST_OK;
      last    <= fetch_last;
    end else if (cmd.single) begin
      rd_byte <= '0;
      has     <= 1'b0;
      status  <= single_status;
      last    <= 1'b1;
    end
  end

  assign stat.read_go     = read_go;
  assign stat.out_last    = last;
  assign out_data.read_byte = rd_byte;
  assign out_data.has_data  = has;
  assign out_data.status    = status;
  assign out_data.last      = last;

  `CBB_ASSERT(a_fill_le_cap, clk, rst, 1'b1, (fill <= cap) && (cap != '0))
  `CBB_ASSERT(a_wp_in_ring, clk, rst, 1'b1, CW'(wp) < cap)
  `CBB_ASSERT(a_mark_in_ring, clk, rst, mv, CW'(mp) < cap)
  `CBB_ASSERT_NEXT(a_cfg_clears, clk, rst, cfg_we, (fill == '0) && !mv && (wp == '0))

endmodule

/* rtl/circular_byte_buffer_with_bookmark.sv */
// ----------------------------------------------------------------------------
// circular_byte_buffer_with_bookmark
// Byte history ring with one bookmark: store, mark, read recent, read from mark.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    cbb_in_t  operation .. length
//   out      source     out_valid / out_ready  cbb_out_t read_byte .. last
//   cfg      sink       cfg_we (no wait)       cfg_wdata capacity, 7 bits
//
// A transaction is taken only in idle; it is decided in the cycle after, and its
// first result is loaded into the result register from the decide state and is
// valid in the send state. Store and mark give one result. Reads stream one byte
// per cycle while out_ready stays high, paced by the registered read port of the
// ring memory. Reset is synchronous and needs no clearing pass; a stalled result
// holds until taken, and the next transaction waits for it.
// ----------------------------------------------------------------------------
module circular_byte_buffer_with_bookmark #(
  parameter int DEPTH = cbb_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  cbb_pkg::cbb_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cbb_pkg::cbb_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [cbb_pkg::CAP_W-1:0] cfg_wdata
);

  cbb_pkg::cbb_cmd_t  cmd;
  cbb_pkg::cbb_stat_t stat;

  // Sequence transactions
  cbb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold the ring and compute results
  cbb_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* tb/ring_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_result_checker
// Watches the command, result and capacity ports of the bookmark byte ring.
// Keeps its own copy of the ring, positions and mark, works out the results
// that each accepted command is due to produce, and compares every accepted
// result field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module ring_result_checker #(
  parameter int DEPTH = cbb_pkg::DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  cbb_pkg::cbb_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  cbb_pkg::cbb_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [cbb_pkg::CAP_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        results_owed
);

  // Shadow of the ring state
  bit [7:0]   ring [0:DEPTH-1];
  int         ring_cap = DEPTH;
  int         wr_pos;
  int         fill_cnt;
  int         mark_pos;
  bit         mark_set;

  cbb_pkg::cbb_out_t owed[$];
  int                fails = 0;

  function automatic int ring_add(int a, int b);
    return (a + b) % ring_cap;
  endfunction

  function automatic int ring_sub(int a, int b);
    return (a % ring_cap + ring_cap - b % ring_cap) % ring_cap;
  endfunction

  function automatic void owe(logic [7:0] b, logic has, cbb_pkg::cbb_status_t st, logic fin);
    cbb_pkg::cbb_out_t r;
    r.read_byte = b;
    r.has_data  = has;
    r.status    = st;
    r.last      = fin;
    owed.push_back(r);
  endfunction

  function automatic void clear_positions();
    wr_pos   = 0;
    fill_cnt = 0;
    mark_pos = 0;
    mark_set = 1'b0;
  endfunction

  // Move the bookmark; leave it untouched on any error
  function automatic cbb_pkg::cbb_status_t place_mark(logic [1:0] origin, int offs);
    int span;
    case (origin)
      cbb_pkg::ORG_MARK: begin
        if (!mark_set) return cbb_pkg::ST_MARK;
        span = ring_sub(wr_pos, mark_pos);
        if (span == 0) span = ring_cap;
        if (offs > span - 1) return cbb_pkg::ST_SIZE;
        mark_pos = ring_add(mark_pos, offs);
      end
      cbb_pkg::ORG_NEWEST: begin
        if (offs >= fill_cnt) return cbb_pkg::ST_SIZE;
        mark_pos = ring_sub(ring_sub(wr_pos, offs), 1);
      end
      cbb_pkg::ORG_OLDEST: begin
        if (offs >= fill_cnt) return cbb_pkg::ST_SIZE;
        mark_pos = ring_add(ring_sub(wr_pos, fill_cnt), offs);
      end
      default: begin
        return cbb_pkg::ST_ARG;
      end
    endcase
    mark_set = 1'b1;
    return cbb_pkg::ST_OK;
  endfunction

  // Apply one command to the shadow state and queue the results it owes
  function automatic void predict_command(cbb_pkg::cbb_in_t c);
    int                   len;
    int                   idx;
    int                   n;
    bit                   done;
    cbb_pkg::cbb_status_t st;
    len = c.length;
    case (c.operation)
      cbb_pkg::OP_STORE: begin
        st = cbb_pkg::ST_OK;
        // Overwriting the marked byte drops the mark
        if (mark_set && wr_pos == mark_pos) begin
          mark_set = 1'b0;
          st = cbb_pkg::ST_MARK;
        end
        ring[wr_pos] = c.data_byte;
        wr_pos = ring_add(wr_pos, 1);
        if (fill_cnt < ring_cap) fill_cnt++;
        owe(8'd0, 1'b0, st, 1'b1);
      end
      cbb_pkg::OP_MARK: begin
        owe(8'd0, 1'b0, place_mark(c.mark_origin, c.distance), 1'b1);
      end
      cbb_pkg::OP_READ_RECENT: begin
        if (len == 0) begin
          owe(8'd0, 1'b0, cbb_pkg::ST_ARG, 1'b1);
        end else if (len > fill_cnt) begin
          owe(8'd0, 1'b0, cbb_pkg::ST_SIZE, 1'b1);
        end else begin
          idx = ring_sub(wr_pos, len);
          for (int i = 0; i < len; i++) begin
            owe(ring[idx], 1'b1, cbb_pkg::ST_OK, i == len - 1);
            idx = ring_add(idx, 1);
          end
        end
      end
      default: begin
        if (len == 0) begin
          owe(8'd0, 1'b0, cbb_pkg::ST_ARG, 1'b1);
        end else if (!mark_set) begin
          owe(8'd0, 1'b0, cbb_pkg::ST_MARK, 1'b1);
        end else begin
          // Stream from the mark, stop at the length or the write position
          idx = mark_pos;
          n = 0;
          done = 1'b0;
          while (!done) begin
            n++;
            done = (n >= len) || (n >= DEPTH) || (ring_add(idx, 1) == wr_pos);
            owe(ring[idx], 1'b1, cbb_pkg::ST_OK, done);
            idx = ring_add(idx, 1);
          end
        end
      end
    endcase
  endfunction

  // Compare one accepted result with the oldest one owed
  function automatic void check_result(cbb_pkg::cbb_out_t got);
    cbb_pkg::cbb_out_t due;
    if (owed.size() == 0) begin
      $error("result transaction with nothing owed: byte %0h has_data %0b status %0d last %0b",
             got.read_byte, got.has_data, got.status, got.last);
      fails++;
      return;
    end
    due = owed.pop_front();
    if (got.read_byte !== due.read_byte) begin
      $error("read_byte: expected %0h, actual %0h", due.read_byte, got.read_byte);
      fails++;
    end
    if (got.has_data !== due.has_data) begin
      $error("has_data: expected %0b, actual %0b", due.has_data, got.has_data);
      fails++;
    end
    if (got.status !== due.status) begin
      $error("status: expected %0d, actual %0d", due.status, got.status);
      fails++;
    end
    if (got.last !== due.last) begin
      $error("last: expected %0b, actual %0b", due.last, got.last);
      fails++;
    end
  endfunction

  // Results first: a result taken at an edge always belongs to an older command
  always @(posedge clk) begin
    if (rst) begin
      ring_cap = DEPTH;
      clear_positions();
      owed.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_we) begin
        ring_cap = (cfg_wdata == 0) ? 1 : ((cfg_wdata > DEPTH) ? DEPTH : int'(cfg_wdata));
        clear_positions();
      end
      if (in_valid && in_ready) predict_command(in_data);
    end
    fail_count   <= fails;
    results_owed <= owed.size();
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bookmark byte ring: a directed pass over error cases and
// corner values, then phases of random command streams at several ring
// capacities and idling mixes. The checker beside the block gives the counts of
// mismatches and of results still owed that decide the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH      = 64;
  localparam int CYCLE_MAX  = 1000000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASES     = 8;
  localparam int MIXED_ITEMS = 45;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  cbb_pkg::cbb_in_t          in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  cbb_pkg::cbb_out_t         out_data;
  logic                      cfg_we = 1'b0;
  logic [cbb_pkg::CAP_W-1:0] cfg_wdata = 7'd64;

  int fail_count;
  int results_owed;

  // Stimulus bookkeeping
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stim_cap = DEPTH;
  int stim_fill = 0;
  int cycle_count = 0;
  int prefill;
  int phase_caps [PHASES] = '{127, 0, 64, 7, 2, 33, 1, 13};

  circular_byte_buffer_with_bookmark #(.DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ring_result_checker #(.DEPTH(DEPTH)) u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_ready    <= 1'b0;
      hold_left    <= HOLD_LEN;
      holds_served <= holds_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic cbb_pkg::cbb_in_t cmd_of(logic [1:0] op, logic [7:0] d, logic [1:0] org,
                                              logic [5:0] offs, logic [6:0] len);
    cbb_pkg::cbb_in_t c;
    c.operation   = op;
    c.data_byte   = d;
    c.mark_origin = org;
    c.distance    = offs;
    c.length      = len;
    return c;
  endfunction

  // Mostly well-formed commands sized to the current fill, some pure noise
  function automatic cbb_pkg::cbb_in_t make_command();
    cbb_pkg::cbb_in_t c;
    int               pick;
    int               top_len;
    c = cmd_of(2'($urandom_range(3)), 8'($urandom_range(255)), 2'($urandom_range(3)),
               6'($urandom_range(63)), 7'($urandom_range(64)));
    pick = $urandom_range(99);
    if (pick < 12) return c;
    if (pick < 50) begin
      c.operation = cbb_pkg::OP_STORE;
    end else if (pick < 68) begin
      c.operation   = cbb_pkg::OP_MARK;
      c.mark_origin = 2'($urandom_range(2));
      if (c.mark_origin == cbb_pkg::ORG_MARK) c.distance = 6'($urandom_range(3));
      else c.distance = 6'((stim_fill > 0) ? $urandom_range(stim_fill - 1) : 0);
    end else if (pick < 84) begin
      c.operation = cbb_pkg::OP_READ_RECENT;
      top_len = (stim_fill > 8) ? 8 : ((stim_fill > 0) ? stim_fill : 1);
      c.length = 7'($urandom_range(top_len, 1));
      if ($urandom_range(15) == 0) c.length = 7'(stim_fill > 0 ? stim_fill : 64);
    end else begin
      c.operation = cbb_pkg::OP_READ_MARK;
      c.length = 7'($urandom_range(12, 1));
      if ($urandom_range(15) == 0) c.length = 7'd64;
    end
    return c;
  endfunction

  // Offer one command and hold it until the block takes it
  task automatic send_command(input cbb_pkg::cbb_in_t cmd);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd.operation == cbb_pkg::OP_STORE && stim_fill < stim_cap) stim_fill++;
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input int v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
    stim_cap  = (v == 0) ? 1 : ((v > DEPTH) ? DEPTH : v);
    stim_fill = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: errors on an empty ring
    send_command(cmd_of(cbb_pkg::OP_READ_RECENT, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd1));
    send_command(cmd_of(cbb_pkg::OP_READ_RECENT, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_READ_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd5));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_UNKNOWN, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_NEWEST, 6'd0, 7'd0));
    // Fill six bytes with extreme patterns
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'hFF, cbb_pkg::ORG_UNKNOWN, 6'd63, 7'd64));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'h55, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'hAA, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'h01, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'h80, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    // Mark moves and range checks
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_OLDEST, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd63, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd5, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_READ_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd64));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_NEWEST, 6'd5, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_READ_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd64));
    send_command(cmd_of(cbb_pkg::OP_READ_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd3));
    send_command(cmd_of(cbb_pkg::OP_READ_RECENT, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd6));
    send_command(cmd_of(cbb_pkg::OP_READ_RECENT, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd64));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_OLDEST, 6'd63, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_NEWEST, 6'd6, 7'd0));
    // One-entry ring: the store lands on the marked byte
    set_capacity(1);
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'h3C, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_MARK, 8'h00, cbb_pkg::ORG_NEWEST, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_READ_MARK, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd64));
    send_command(cmd_of(cbb_pkg::OP_STORE, 8'hC3, cbb_pkg::ORG_MARK, 6'd0, 7'd0));
    send_command(cmd_of(cbb_pkg::OP_READ_RECENT, 8'h00, cbb_pkg::ORG_MARK, 6'd0, 7'd1));

    // Random phases: new capacity, new idling mix, prefill then mixed commands
    for (int p = 0; p < PHASES; p++) begin
      set_capacity(phase_caps[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 51; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 51; end
        default: begin gap_pct = 9; stall_pct <= 9; end
      endcase
      prefill = $urandom_range(stim_cap + 2, stim_cap / 2);
      repeat (prefill) begin
        send_command(cmd_of(cbb_pkg::OP_STORE, 8'($urandom_range(255)), 2'($urandom_range(3)),
                            6'($urandom_range(63)), 7'($urandom_range(64))));
      end
      for (int i = 0; i < MIXED_ITEMS; i++) begin
        // Hold the receiver off while commands keep coming
        if (p == 0 && i == 15) hold_requests <= hold_requests + 1;
        // Pause the sender until the block has emptied
        if (p == 0 && i == 30) drain();
        send_command(make_command());
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/cbb_pkg.sv
rtl/cbb_ctrl.sv
rtl/cbb_dpath.sv
rtl/circular_byte_buffer_with_bookmark.sv
tb/ring_result_checker.sv
tb/tb_top.sv
